### src/cfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

  // Result status codes
  localparam logic [1:0] ST_VERSION = 2'd0;
  localparam logic [1:0] ST_LENGTH  = 2'd1;
  localparam logic [1:0] ST_CRC     = 2'd2;
  localparam logic [1:0] ST_DATA    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_START_ONE = 2'd0;
  localparam logic [1:0] REG_START_TWO = 2'd1;
  localparam logic [1:0] REG_VERSION   = 2'd2;
  localparam logic [1:0] REG_LIMIT     = 2'd3;

  // Frame layout
  localparam logic [6:0] HDR_BYTES    = 7'd7;  // version, four header bytes, length
  localparam logic [6:0] IDX_LEN_LOW  = 7'd5;
  localparam logic [6:0] IDX_LEN_HIGH = 7'd6;
  localparam logic [6:0] IDX_VERSION  = 7'd0;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] good;
    logic [31:0] crc;
    logic [31:0] length;
    logic [31:0] version;
    logic [31:0] discard;
  } counts_t;

  // One command from the front to the back: an error beat or a frame dump
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] body_len;
    counts_t    counts;
  } cmd_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/crc_checked_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Error results reach m_tvalid via the command queue and the output register;
// a good frame's first body beat follows its last CRC byte via the queue,
// dump state and store read, then one beat per cycle while m_tready is high.
// Throughput: one byte per cycle; input stalls during a dump or full queue.
// Reset: rst clears control state, counters and config to their defaults.

module crc_checked_frame_parser
  import cfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 48,
  parameter int STORE_DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration writes
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_data,
  // received bytes
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // rx_byte
  // results
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // frame_byte[7:0], discarded_count[39:8], version_error_count[71:40],
  // length_error_count[103:72], crc_error_count[135:104],
  // good_frame_count[167:136]
  output logic [167:0]      m_tdata,
  output logic [1:0]        m_tuser,   // status
  output logic              m_tlast    // last_flag
);

  localparam int AW = $clog2(STORE_DEPTH);

  // Front: hunt, header checks, CRC, body writes into the back's store.
  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_data;
  logic          q_push, q_full, q_valid, q_pop;
  cmd_t          q_cmd, q_head;
  logic          dump_done;

  cfp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .st_we     (st_we),
    .st_addr   (st_addr),
    .st_data   (st_data),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_full    (q_full),
    .dump_done (dump_done)
  );

  // Short command queue: errors can wait here while the front keeps hunting.
  cfp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  // Back: emit error beats or dump the stored body, one beat per cycle while m_tready is high.
  cfp_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .st_we     (st_we),
    .st_addr   (st_addr),
    .st_data   (st_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .dump_done (dump_done),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

### src/cfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_front
  import cfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 48,
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,
  output logic                                st_we,
  output logic [$clog2(STORE_DEPTH)-1:0]      st_addr,
  output logic [7:0]                          st_data,
  output logic                                q_push,
  output cmd_t                                q_cmd,
  input  wire logic                           q_full,
  input  wire logic                           dump_done
);

  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int CAP_INT = (MAX_PAYLOAD < STORE_DEPTH - 7) ? MAX_PAYLOAD : STORE_DEPTH - 7;
  localparam logic [5:0] CAP = 6'(CAP_INT);

  logic [7:0]  start_one, start_two, version;
  logic [5:0]  plimit;
  logic [6:0]  pos, pos_next;
  logic        known, known_next;
  logic [6:0]  body_len, body_len_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_low, crc_low_next;
  logic [7:0]  len_low, len_low_next;
  counts_t     cnt, cnt_next;
  logic        hold, hold_next;

  logic        accept;
  logic [6:0]  idx;
  logic [15:0] len16;
  logic [5:0]  lim;

  assign s_tready = !hold && !q_full;
  assign accept   = s_tvalid && s_tready;
  assign idx      = pos - 7'd2;
  assign len16    = {s_tdata, len_low};
  assign lim      = (plimit > CAP) ? CAP : plimit;
  assign st_addr  = idx[AW-1:0];
  assign st_data  = s_tdata;

  always_comb begin
    pos_next      = pos;
    known_next    = known;
    body_len_next = body_len;
    crc_next      = crc;
    crc_low_next  = crc_low;
    len_low_next  = len_low;
    cnt_next      = cnt;
    hold_next     = hold && !dump_done;
    st_we         = 1'b0;
    q_push        = 1'b0;
    q_cmd         = '0;
    if (accept) begin
      if (pos == 7'd0) begin
        if (s_tdata == start_one) pos_next = 7'd1;
        else cnt_next.discard = cnt.discard + 32'd1;
      end else if (pos == 7'd1) begin
        if (s_tdata == start_two) begin
          pos_next = 7'd2;
        end else if (s_tdata != start_one) begin
          pos_next = 7'd0;
          cnt_next.discard = cnt.discard + 32'd1;
        end
      end else begin
        pos_next = pos + 7'd1;
        if (!known) begin
          if (idx == IDX_VERSION && s_tdata != version) begin
            cnt_next.version = cnt.version + 32'd1;
            q_push     = 1'b1;
            q_cmd.kind = ST_VERSION;
            pos_next   = 7'd0;
            crc_next   = CRC_INIT;
          end else begin
            st_we    = 1'b1;
            crc_next = crc16_byte(crc, s_tdata);
            if (idx == IDX_LEN_LOW) len_low_next = s_tdata;
            if (idx == IDX_LEN_HIGH) begin
              if (len16 > {10'd0, lim}) begin
                cnt_next.length = cnt.length + 32'd1;
                q_push     = 1'b1;
                q_cmd.kind = ST_LENGTH;
                pos_next   = 7'd0;
                crc_next   = CRC_INIT;
              end else begin
                known_next    = 1'b1;
                body_len_next = HDR_BYTES + {1'b0, len16[5:0]};
              end
            end
          end
        end else if (idx < body_len) begin
          st_we    = 1'b1;
          crc_next = crc16_byte(crc, s_tdata);
        end else if (idx == body_len) begin
          crc_low_next = s_tdata;
        end else begin
          // CRC high byte: check, then restart the hunt either way
          q_push       = 1'b1;
          pos_next     = 7'd0;
          known_next   = 1'b0;
          crc_next     = CRC_INIT;
          crc_low_next = 8'd0;
          if ({s_tdata, crc_low} != crc) begin
            cnt_next.crc = cnt.crc + 32'd1;
            q_cmd.kind   = ST_CRC;
          end else begin
            cnt_next.good  = cnt.good + 32'd1;
            q_cmd.kind     = ST_DATA;
            q_cmd.body_len = body_len;
            hold_next      = 1'b1;
          end
        end
      end
    end
    q_cmd.counts = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_one <= 8'd170;
      start_two <= 8'd85;
      version   <= 8'd1;
      plimit    <= 6'd48;
      pos       <= 7'd0;
      known     <= 1'b0;
      crc       <= CRC_INIT;
      crc_low   <= 8'd0;
      cnt       <= '0;
      hold      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_ONE: start_one <= cfg_data;
          REG_START_TWO: start_two <= cfg_data;
          REG_VERSION:   version   <= cfg_data;
          REG_LIMIT:     plimit    <= cfg_data[5:0];
          default: ;
        endcase
      end
      pos     <= pos_next;
      known   <= known_next;
      crc     <= crc_next;
      crc_low <= crc_low_next;
      cnt     <= cnt_next;
      hold    <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    body_len <= body_len_next;
    len_low  <= len_low_next;
  end

endmodule

`default_nettype wire

### src/cfp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_fifo
  import cfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      valid,
  output cmd_t      head,
  input  wire logic pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t              slots [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [PW:0]       count;

  assign full  = (count == (PW + 1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && valid) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW + 1)'(push && !full) - (PW + 1)'(pop && valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

### src/cfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_back
  import cfp_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      st_we,
  input  wire logic [$clog2(STORE_DEPTH)-1:0] st_addr,
  input  wire logic [7:0]                st_data,
  input  wire logic                      q_valid,
  input  wire cmd_t                      q_head,
  output logic                           q_pop,
  output logic                           dump_done,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [167:0]                   m_tdata,
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [7:0] body_mem [STORE_DEPTH];
  logic [7:0] rdata;
  logic       out_valid;
  logic [1:0] status;
  logic       last;
  counts_t    cur;
  logic       dumping;
  logic [6:0] idx, len;
  logic       advance, rd_en, last_issue;

  assign advance    = !out_valid || m_tready;
  assign rd_en      = advance && dumping;
  assign last_issue = (idx == len - 7'd1);
  assign dump_done  = rd_en && last_issue;
  assign q_pop      = advance && !dumping && q_valid;

  assign m_tvalid = out_valid;
  assign m_tuser  = status;
  assign m_tlast  = last;
  assign m_tdata  = {cur.good, cur.crc, cur.length, cur.version, cur.discard,
                     (status == ST_DATA) ? rdata : 8'd0};

  always_ff @(posedge clk) begin
    if (st_we) body_mem[st_addr] <= st_data;
    if (rd_en) rdata <= body_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      dumping   <= 1'b0;
    end else if (advance) begin
      if (dumping) begin
        out_valid <= 1'b1;
        if (last_issue) dumping <= 1'b0;
      end else if (q_valid) begin
        out_valid <= (q_head.kind != ST_DATA);
        dumping   <= (q_head.kind == ST_DATA);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (dumping) begin
        status <= ST_DATA;
        last   <= last_issue;
        idx    <= idx + 7'd1;
      end else if (q_valid) begin
        cur    <= q_head.counts;
        status <= q_head.kind;
        last   <= 1'b1;
        len    <= q_head.body_len;
        idx    <= 7'd0;
      end
    end
  end

endmodule

`default_nettype wire

### src/cfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_checker
  import cfp_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [167:0] m_tdata,
  input wire logic [1:0]   m_tuser,
  input wire logic         m_tlast
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_DATA |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("error beat not single or carries data");

  a_counts_steady: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast && m_tuser == ST_DATA
      |=> $stable(m_tdata[167:8]))
    else $error("counters moved inside a frame dump");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_DATA && !m_tlast |-> !s_tready)
    else $error("input taken during a frame dump");

endmodule

bind crc_checked_frame_parser cfp_checker u_cfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/crc_checked_frame_parser_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_frame_parser_checker
  import cfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 48,
  parameter int STORE_DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [7:0]   s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [167:0] m_tdata,
  input  wire logic [1:0]   m_tuser,
  input  wire logic         m_tlast,
  output int                failures,
  output int                pending,
  output logic              hunting,
  output int                rx_bytes,
  output int                good_frames,
  output int                error_beats
);

  localparam int AW = $clog2(STORE_DEPTH);

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  frame_byte;
    logic        last;
    logic [31:0] discards;
    logic [31:0] version_errs;
    logic [31:0] length_errs;
    logic [31:0] crc_errs;
    logic [31:0] frames;
  } frame_beat_t;

  // register copies
  logic [7:0]  start_one;
  logic [7:0]  start_two;
  logic [7:0]  version_want;
  logic [5:0]  length_cap;

  // parser state
  logic [6:0]  byte_pos;
  logic [6:0]  body_len;   // 0 while the length field has not arrived
  logic [15:0] body_crc;
  logic [7:0]  crc_low;
  logic [7:0]  body_bytes [STORE_DEPTH];
  logic [31:0] discards;
  logic [31:0] version_errs;
  logic [31:0] length_errs;
  logic [31:0] crc_errs;
  logic [31:0] frames;

  frame_beat_t due_beats [$];
  int          mismatches;
  int          n_rx;
  int          n_good;
  int          n_err;

  task automatic restart_hunt();
    byte_pos = '0;
    body_len = '0;
    body_crc = CRC_INIT;
    crc_low  = '0;
  endtask

  function automatic void push_beat(input logic [1:0] st, input logic [7:0] fb,
                                    input logic lst);
    frame_beat_t r;
    r.status       = st;
    r.frame_byte   = fb;
    r.last         = lst;
    r.discards     = discards;
    r.version_errs = version_errs;
    r.length_errs  = length_errs;
    r.crc_errs     = crc_errs;
    r.frames       = frames;
    due_beats.push_back(r);
  endfunction

  // Store one body byte and fold it into the CRC, MSB first.
  task automatic take_body(input logic [6:0] idx, input logic [7:0] b);
    logic [15:0] c;
    if (idx < STORE_DEPTH) body_bytes[idx[AW-1:0]] = b;
    c = body_crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    body_crc = c;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [6:0] idx;
    int         len;
    int         cap;
    if (byte_pos == 0) begin
      if (b == start_one) byte_pos = 7'd1;
      else discards++;
    end else if (byte_pos == 1) begin
      // equal start bytes: the second one counts as start two
      if (b == start_two) begin
        byte_pos = 7'd2;
      end else if (b != start_one) begin
        restart_hunt();
        discards++;
      end
    end else begin
      idx      = byte_pos - 7'd2;
      byte_pos = byte_pos + 7'd1;
      if (body_len == 0) begin
        if (idx == IDX_VERSION && b != version_want) begin
          version_errs++;
          restart_hunt();
          push_beat(ST_VERSION, 8'h00, 1'b1);
          n_err++;
        end else begin
          take_body(idx, b);
          if (idx == IDX_LEN_HIGH) begin
            len = int'({body_bytes[IDX_LEN_HIGH[AW-1:0]],
                        body_bytes[IDX_LEN_LOW[AW-1:0]]});
            cap = int'(length_cap);
            if (cap > MAX_PAYLOAD) cap = MAX_PAYLOAD;
            if (cap > STORE_DEPTH - HDR_BYTES) cap = STORE_DEPTH - HDR_BYTES;
            if (len > cap) begin
              length_errs++;
              restart_hunt();
              push_beat(ST_LENGTH, 8'h00, 1'b1);
              n_err++;
            end else begin
              body_len = HDR_BYTES + 7'(len);
            end
          end
        end
      end else if (idx < body_len) begin
        take_body(idx, b);
      end else if (idx == body_len) begin
        crc_low = b;
      end else if ({b, crc_low} != body_crc) begin
        crc_errs++;
        restart_hunt();
        push_beat(ST_CRC, 8'h00, 1'b1);
        n_err++;
      end else begin
        // count the frame first: its beats carry the new total
        frames++;
        n_good++;
        for (int i = 0; i < body_len && i < STORE_DEPTH; i++) begin
          push_beat(ST_DATA, body_bytes[AW'(i)],
                    (i + 1 == body_len) || (i + 1 == STORE_DEPTH));
        end
        restart_hunt();
      end
    end
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      start_one    = 8'd170;
      start_two    = 8'd85;
      version_want = 8'd1;
      length_cap   = 6'd48;
      discards     = '0;
      version_errs = '0;
      length_errs  = '0;
      crc_errs     = '0;
      frames       = '0;
      restart_hunt();
      due_beats.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat: status %0d byte %02h last %0b",
                     $time, m_tuser, m_tdata[7:0], m_tlast);
        end else begin
          want = due_beats.pop_front();
          if (m_tuser !== want.status || m_tdata[7:0] !== want.frame_byte ||
              m_tlast !== want.last || m_tdata[39:8] !== want.discards ||
              m_tdata[71:40] !== want.version_errs ||
              m_tdata[103:72] !== want.length_errs ||
              m_tdata[135:104] !== want.crc_errs ||
              m_tdata[167:136] !== want.frames) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch, expected st %0d byte %02h last %0b %s",
                       $time, want.status, want.frame_byte, want.last, "cnt");
              $display("    expected cnt %0d %0d %0d %0d %0d",
                       want.discards, want.version_errs, want.length_errs,
                       want.crc_errs, want.frames);
              $display("    actual   st %0d byte %02h last %0b",
                       m_tuser, m_tdata[7:0], m_tlast);
              $display("    actual   cnt %0d %0d %0d %0d %0d",
                       m_tdata[39:8], m_tdata[71:40], m_tdata[103:72],
                       m_tdata[135:104], m_tdata[167:136]);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_ONE: start_one    = cfg_data;
          REG_START_TWO: start_two    = cfg_data;
          REG_VERSION:   version_want = cfg_data;
          REG_LIMIT:     length_cap   = cfg_data[5:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        n_rx++;
        parse_rx_byte(s_tdata);
      end
    end
    failures    <= mismatches;
    pending     <= due_beats.size();
    hunting     <= (byte_pos == 0);
    rx_bytes    <= n_rx;
    good_frames <= n_good;
    error_beats <= n_err;
  end

endmodule

`default_nettype wire

### tb/crc_checked_frame_parser_tb.sv
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_frame_parser_tb;
  import cfp_pkg::*;

  localparam int MAX_PAYLOAD     = 48;
  localparam int STORE_DEPTH     = 64;
  localparam int BYTES_PER_PHASE = 70;   // random bytes per register setting
  localparam int HOLD_OFF_CYCLES = 400;  // long output stall, fills the block
  localparam int SETTLE_CYCLES   = 8;    // covers the dump latency
  localparam int TAIL_CYCLES     = 20;

  typedef enum {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_VERSION,
    FR_BAD_LENGTH,
    FR_TRUNCATED
  } frame_kind_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [7:0]   cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;     // rx_byte
  logic         m_tvalid;
  logic         m_tready;
  // frame_byte, discarded, version errors, length errors, crc errors, good frames
  logic [167:0] m_tdata;
  logic [1:0]   m_tuser;     // status
  logic         m_tlast;     // last_flag

  int   failures;
  int   pending;
  logic hunting;
  int   rx_bytes;
  int   good_frames;
  int   error_beats;

  // Register values the stimulus builds frames against; reset defaults first.
  logic [7:0] sof_one   = 8'd170;
  logic [7:0] sof_two   = 8'd85;
  logic [7:0] ver_now   = 8'd1;
  logic [5:0] limit_now = 6'd48;

  logic calm         = 1'b0;  // set: neither side idles
  int   hold_off_req = 0;     // bump to ask the receiver for a long stall
  int   rx_sent      = 0;

  crc_checked_frame_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  crc_checked_frame_parser_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .failures    (failures),
    .pending     (pending),
    .hunting     (hunting),
    .rx_bytes    (rx_bytes),
    .good_frames (good_frames),
    .error_beats (error_beats)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL crc_checked_frame_parser");
    $finish;
  end

  // Result side: accept at random, except for the long hold-off and calm stretches.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != hold_seen) begin
        hold_seen = hold_off_req;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // Offer one byte, with a random gap ahead of it, and hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    rx_sent++;
  endtask

  // Build and send one frame. plen is the payload length, or the declared
  // length for a length error. repeats adds extra copies of start byte one.
  task automatic send_frame(input frame_kind_t kind, input int plen, input int repeats);
    logic [7:0]  body [$];
    logic [7:0]  v;
    logic [15:0] len;
    logic [15:0] c;
    int          cut;
    send_byte(sof_one);
    repeat (repeats) send_byte(sof_one);
    send_byte(sof_two);
    if (kind == FR_BAD_VERSION) begin
      do v = 8'($urandom); while (v == ver_now);
      send_byte(v);
    end else begin
      len = 16'(plen);
      body.push_back(ver_now);
      repeat (4) body.push_back(8'($urandom));
      body.push_back(len[7:0]);
      body.push_back(len[15:8]);
      if (kind != FR_BAD_LENGTH) begin
        repeat (plen) body.push_back(8'($urandom));
        // CRC-16/CCITT-FALSE over the body, MSB first
        c = 16'hFFFF;
        foreach (body[i]) begin
          c = c ^ {body[i], 8'h00};
          repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        if (kind == FR_BAD_CRC) c = c ^ 16'($urandom_range(16'hFFFF, 1));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
      end
      // truncate: drop the tail so the following bytes get absorbed as body
      cut = (kind == FR_TRUNCATED) ? $urandom_range(body.size() - 1, 1) : body.size();
      for (int i = 0; i < cut; i++) send_byte(body[i]);
    end
  endtask

  // Mostly well-formed frames with random content; the rest errors and noise.
  task automatic random_stream(input int budget);
    int          stop;
    int          pick;
    int          cap;
    int          plen;
    int          r;
    frame_kind_t kind;
    stop = rx_sent + budget;
    cap  = (limit_now > MAX_PAYLOAD) ? MAX_PAYLOAD : limit_now;
    while (rx_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        kind = (pick < 55) ? FR_GOOD :
               (pick < 65) ? FR_BAD_CRC :
               (pick < 72) ? FR_BAD_LENGTH :
               (pick < 76) ? FR_BAD_VERSION : FR_TRUNCATED;
        // favor short payloads; now and then the largest one allowed
        r = $urandom_range(9);
        plen = (r == 0) ? cap :
               (r < 3) ? $urandom_range(cap, 0) : $urandom_range((cap < 6) ? cap : 6, 0);
        if (kind == FR_BAD_LENGTH)
          plen = $urandom_range(1) ? cap + 1 : $urandom_range(16'hFFFF, cap + 1);
        send_frame(kind, plen,
                   (sof_one != sof_two && $urandom_range(9) == 0) ? 1 : 0);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end
    end
  endtask

  // Bring the parser back to the hunt and wait until every result is out.
  task automatic settle();
    logic [7:0] fill;
    // a filler that is neither start byte ends any frame in progress
    fill = sof_one + 8'd1;
    if (fill == sof_two) fill = sof_one + 8'd2;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (!hunting) begin
      send_byte(fill);
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [7:0] one, input logic [7:0] two,
                                input logic [7:0] ver, input logic [5:0] cap);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_ONE;
    cfg_data  <= one;
    @(posedge clk);
    cfg_index <= REG_START_TWO;
    cfg_data  <= two;
    @(posedge clk);
    cfg_index <= REG_VERSION;
    cfg_data  <= ver;
    @(posedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data  <= {2'b00, cap};
    @(posedge clk);
    cfg_we    <= 1'b0;
    sof_one   = one;
    sof_two   = two;
    ver_now   = ver;
    limit_now = cap;
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_START_ONE;
    cfg_data  <= 8'h00;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset settings: noise at both byte extremes, a repeated start
    // byte ahead of an empty good frame, a wrong version, the largest length.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(FR_GOOD, 0, 1);
    send_frame(FR_BAD_VERSION, 0, 0);
    send_frame(FR_BAD_LENGTH, 16'hFFFF, 0);
    random_stream(BYTES_PER_PHASE);

    // Extremes: start bytes 0 and 255, version 255, no payload allowed.
    write_settings(8'h00, 8'hFF, 8'hFF, 6'd0);
    random_stream(BYTES_PER_PHASE);

    // Equal start bytes, version 0, top limit; run with no idling at all.
    calm <= 1'b1;
    write_settings(8'h7E, 8'h7E, 8'h00, 6'd57);
    random_stream(BYTES_PER_PHASE);
    calm <= 1'b0;

    // Random settings; stall the result side long enough to back up the input.
    write_settings(8'($urandom), 8'($urandom), 8'($urandom), 6'($urandom_range(57, 0)));
    hold_off_req <= hold_off_req + 1;
    random_stream(BYTES_PER_PHASE);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d received bytes under four register settings, incl. equal",
             rx_bytes);
    $display("start bytes and limits 0 and 57: %0d good frames, %0d error results.",
             good_frames, error_beats);
    if (failures == 0) begin
      $display("PASS crc_checked_frame_parser");
    end else begin
      $display("FAIL crc_checked_frame_parser");
    end
    $finish;
  end

endmodule

`default_nettype wire
